>>> design/ucf_pkg.sv
// Shared types, folding tables and the code point fold function
`timescale 1ns / 1ps

package ucf_pkg;

    // input transaction payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // output transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_line_end;
    } t_out;

    // code point of up to 21 bits
    typedef logic [20:0] t_cp;

    // byte list formed for one input transaction, before folding
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            seq;
        logic            last;
    } t_work;

    // byte group waiting to be sent, one byte per output transaction
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            last;
    } t_grp;

    localparam int NUM_DELTA  = 31;
    localparam int NUM_PAIRS  = 7;
    localparam int NUM_SINGLE = 6;

    // ranges folded by a fixed offset
    localparam t_cp DELTA_LO [NUM_DELTA] = '{
        21'h00041, 21'h000C0, 21'h000D8, 21'h00386, 21'h00388, 21'h0038C,
        21'h0038E, 21'h00391, 21'h003A3, 21'h003C2, 21'h00400, 21'h00410,
        21'h00531, 21'h01F08, 21'h01F18, 21'h01F28, 21'h01F38, 21'h01F48,
        21'h01F68, 21'h01F88, 21'h01F98, 21'h01FA8, 21'h01FB8, 21'h01FBA,
        21'h01FC8, 21'h01FD8, 21'h01FDA, 21'h01FE8, 21'h01FEA, 21'h01FF8,
        21'h01FFA
    };
    localparam t_cp DELTA_HI [NUM_DELTA] = '{
        21'h0005A, 21'h000D6, 21'h000DE, 21'h00386, 21'h0038A, 21'h0038C,
        21'h0038F, 21'h003A1, 21'h003AB, 21'h003C2, 21'h0040F, 21'h0042F,
        21'h00556, 21'h01F0F, 21'h01F1D, 21'h01F2F, 21'h01F3F, 21'h01F4D,
        21'h01F6F, 21'h01F8F, 21'h01F9F, 21'h01FAF, 21'h01FB9, 21'h01FBB,
        21'h01FCB, 21'h01FD9, 21'h01FDB, 21'h01FE9, 21'h01FEB, 21'h01FF9,
        21'h01FFB
    };
    localparam logic [7:0] DELTA_OFS [NUM_DELTA] = '{
        8'h20, 8'h20, 8'h20, 8'h26, 8'h25, 8'h40, 8'h3F, 8'h20, 8'h20,
        8'h01, 8'h50, 8'h20, 8'h30,
        8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8,
        8'hF8, 8'hB6, 8'hAA, 8'hF8, 8'h9C, 8'hF8, 8'h90, 8'h80, 8'h82
    };

    // ranges of alternating upper and lower case pairs
    localparam t_cp PAIR_LO [NUM_PAIRS] = '{
        21'h00100, 21'h00132, 21'h00139, 21'h0014A, 21'h00179, 21'h01E00,
        21'h01EA0
    };
    localparam t_cp PAIR_HI [NUM_PAIRS] = '{
        21'h0012F, 21'h00137, 21'h00148, 21'h00177, 21'h0017E, 21'h01E95,
        21'h01EFF
    };

    // single code point mappings
    localparam t_cp SINGLE_FROM [NUM_SINGLE] = '{
        21'h00178, 21'h01F59, 21'h01F5B, 21'h01F5D, 21'h01F5F, 21'h01FEC
    };
    localparam t_cp SINGLE_TO [NUM_SINGLE] = '{
        21'h000FF, 21'h01F51, 21'h01F53, 21'h01F55, 21'h01F57, 21'h01FE5
    };

    // simple case fold of one code point, identity when no entry matches
    function automatic t_cp fold_point(input t_cp cp);
        t_cp  f;
        logic hit;
        f   = cp;
        hit = 1'b0;
        for (int n = 0; n < NUM_DELTA; n++) begin
            if (!hit && cp >= DELTA_LO[n] && cp <= DELTA_HI[n]) begin
                f   = cp + {{13{DELTA_OFS[n][7]}}, DELTA_OFS[n]};
                hit = 1'b1;
            end
        end
        for (int n = 0; n < NUM_PAIRS; n++) begin
            if (!hit && cp >= PAIR_LO[n] && cp <= PAIR_HI[n]
                && cp[0] == PAIR_LO[n][0]) begin
                f   = cp + 21'd1;
                hit = 1'b1;
            end
        end
        for (int n = 0; n < NUM_SINGLE; n++) begin
            if (!hit && cp == SINGLE_FROM[n]) begin
                f   = SINGLE_TO[n];
                hit = 1'b1;
            end
        end
        return f;
    endfunction

endpackage

>>> design/ucf_front.sv
// Sequence tracking, fold enable register and the work register
`timescale 1ns / 1ps

module ucf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ucf_pkg::t_in  i_in_data,
    output logic          o_work_vld,
    output ucf_pkg::t_work o_work,
    input  logic          i_work_take
);

    localparam logic [2:0] LEN_NONE = 3'd0;

    logic             r_fold_en;
    logic [2:0]       r_exp;
    logic [2:0]       n_exp;
    logic [1:0]       r_held;
    logic [1:0]       n_held;
    logic [2:0][7:0]  r_pend;
    logic [2:0][7:0]  n_pend;
    logic             r_work_vld;
    ucf_pkg::t_work   r_work;
    ucf_pkg::t_work   n_work;

    logic             in_acc;
    logic [2:0]       lead_len;
    logic [1:0]       flush_n;
    logic             tail_en;
    logic [7:0]       tail;
    logic             seq;
    logic             done;
    logic [7:0]       b;

    assign b          = i_in_data.in_byte;
    assign o_in_ready = !r_work_vld || i_work_take;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_work_vld = r_work_vld;
    assign o_work     = r_work;

    // length class of a lead byte
    always_comb begin
        case (b) inside
            [8'hC2:8'hDF]: lead_len = 3'd2;
            [8'hE0:8'hEF]: lead_len = 3'd3;
            [8'hF0:8'hF4]: lead_len = 3'd4;
            default:       lead_len = LEN_NONE;
        endcase
    end

    // next sequence state and the list of held bytes plus one tail byte
    always_comb begin
        n_exp   = r_exp;
        n_held  = r_held;
        n_pend  = r_pend;
        flush_n = 2'd0;
        tail_en = 1'b0;
        tail    = b;
        seq     = 1'b0;
        done    = 1'b0;
        if (!r_fold_en) begin
            flush_n = r_held;
            n_exp   = LEN_NONE;
            n_held  = 2'd0;
            tail_en = 1'b1;
            done    = 1'b1;
        end else if (r_exp != LEN_NONE) begin
            if (b[7:6] == 2'b10 && r_held != 2'd0 && {1'b0, r_held} < r_exp) begin
                done = 1'b1;
                if ({1'b0, r_held} + 3'd1 == r_exp) begin
                    // sequence complete
                    flush_n = r_held;
                    tail_en = 1'b1;
                    seq     = 1'b1;
                    n_exp   = LEN_NONE;
                    n_held  = 2'd0;
                end else begin
                    n_pend[r_held] = b;
                    n_held         = r_held + 2'd1;
                    if (i_in_data.in_last) begin
                        // line ends inside the sequence
                        flush_n = r_held;
                        tail_en = 1'b1;
                        n_exp   = LEN_NONE;
                        n_held  = 2'd0;
                    end
                end
            end else begin
                // broken sequence, held bytes go out verbatim
                flush_n = r_held;
                n_exp   = LEN_NONE;
                n_held  = 2'd0;
            end
        end
        if (!done) begin
            if (!b[7]) begin
                tail_en = 1'b1;
                tail    = (b inside {[8'h41:8'h5A]}) ? b + 8'h20 : b;
            end else if (lead_len != LEN_NONE && !i_in_data.in_last) begin
                n_pend[0] = b;
                n_held    = 2'd1;
                n_exp     = lead_len;
            end else begin
                tail_en = 1'b1;
            end
        end
    end

    // assemble the work item
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_work.bytes[k] = (k < int'(flush_n)) ? r_pend[k] : tail;
        end
        n_work.bytes[3] = tail;
        n_work.cnt      = {1'b0, flush_n} + {2'b00, tail_en};
        n_work.seq      = seq;
        n_work.last     = i_in_data.in_last;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_en  <= 1'b1;
            r_exp      <= LEN_NONE;
            r_held     <= 2'd0;
            r_work_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fold_en <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_exp      <= n_exp;
                r_held     <= n_held;
                r_work_vld <= 1'b1;
            end else if (i_work_take) begin
                r_work_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend <= n_pend;
            r_work <= n_work;
        end
    end

endmodule

>>> design/ucf_fold.sv
// Decode of a complete sequence, case fold and re-encode
`timescale 1ns / 1ps

module ucf_fold (
    input  ucf_pkg::t_work i_work,
    output ucf_pkg::t_grp  o_grp
);

    ucf_pkg::t_cp cp;
    ucf_pkg::t_cp f;

    // decode the code point from its length class
    always_comb begin
        case (i_work.cnt)
            3'd2:    cp = {10'd0, i_work.bytes[0][4:0], i_work.bytes[1][5:0]};
            3'd3:    cp = {5'd0, i_work.bytes[0][3:0], i_work.bytes[1][5:0],
                           i_work.bytes[2][5:0]};
            3'd4:    cp = {i_work.bytes[0][2:0], i_work.bytes[1][5:0],
                           i_work.bytes[2][5:0], i_work.bytes[3][5:0]};
            default: cp = '0;
        endcase
    end

    assign f = ucf_pkg::fold_point(cp);

    // raw bytes unless a folded code point needs re-encoding
    always_comb begin
        o_grp.bytes = i_work.bytes;
        o_grp.cnt   = i_work.cnt;
        o_grp.last  = i_work.last;
        if (i_work.seq && f != cp) begin
            if (f < 21'h80) begin
                o_grp.bytes[0] = f[7:0];
                o_grp.cnt      = 3'd1;
            end else if (f < 21'h800) begin
                o_grp.bytes[0] = {3'b110, f[10:6]};
                o_grp.bytes[1] = {2'b10, f[5:0]};
                o_grp.cnt      = 3'd2;
            end else if (f < 21'h10000) begin
                o_grp.bytes[0] = {4'b1110, f[15:12]};
                o_grp.bytes[1] = {2'b10, f[11:6]};
                o_grp.bytes[2] = {2'b10, f[5:0]};
                o_grp.cnt      = 3'd3;
            end else begin
                o_grp.bytes[0] = {5'b11110, f[20:18]};
                o_grp.bytes[1] = {2'b10, f[17:12]};
                o_grp.bytes[2] = {2'b10, f[11:6]};
                o_grp.bytes[3] = {2'b10, f[5:0]};
                o_grp.cnt      = 3'd4;
            end
        end
    end

endmodule

>>> design/ucf_out.sv
// Result group register and byte serializer for the output channel
`timescale 1ns / 1ps

module ucf_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_work_vld,
    input  ucf_pkg::t_grp i_grp,
    output logic          o_work_take,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ucf_pkg::t_out o_out_data
);

    logic          r_vld;
    logic [1:0]    r_idx;
    ucf_pkg::t_grp r_grp;
    logic          fin;
    logic          out_acc;
    logic          grp_free;
    logic          load;

    assign fin         = (r_idx == r_grp.cnt[1:0] - 2'd1);
    assign out_acc     = r_vld && i_out_ready;
    assign grp_free    = !r_vld || (i_out_ready && fin);
    // a work item with no bytes retires without using the group register
    assign o_work_take = i_work_vld && (i_grp.cnt == 3'd0 || grp_free);
    assign load        = o_work_take && i_grp.cnt != 3'd0;

    assign o_out_valid             = r_vld;
    assign o_out_data.out_byte     = r_grp.bytes[r_idx];
    assign o_out_data.out_last     = fin;
    assign o_out_data.out_line_end = fin && r_grp.last;

    // group valid and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= 2'd0;
        end else if (load) begin
            r_vld <= 1'b1;
            r_idx <= 2'd0;
        end else if (out_acc) begin
            if (fin) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // group payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_grp <= i_grp;
        end
    end

endmodule

>>> design/utf8_case_fold_stream_top.sv
// Streaming UTF-8 simple case folder, top level
// One input byte is accepted per cycle unless the work register stays full.
// The input stage tracks open multi-byte sequences and registers a work
// item; the fold stage decodes, folds and re-encodes it into a result group
// register; the output side sends the group one byte per transaction. The
// result group register loads from the work register, once the group before
// it is done, and then presents the first output byte. While the output is
// ready, input and output each move one byte per cycle, so the sustained rate
// is one input transaction per cycle while each causes at most one output
// byte; a transaction causing n bytes (up to four, for a completed
// character or a broken or flushed sequence) holds the output port until all
// n are sent, and a lead or continuation byte that is held causes none.
// Clearing fold_enable passes bytes through; change it only while idle.
`timescale 1ns / 1ps

module utf8_case_fold_stream_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ucf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ucf_pkg::t_out o_out_data
);

    logic           work_vld;
    logic           work_take;
    ucf_pkg::t_work work;
    ucf_pkg::t_grp  grp;

    // sequence tracking and work register
    ucf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_work_vld    (work_vld),
        .o_work        (work),
        .i_work_take   (work_take)
    );

    // fold and re-encode
    ucf_fold u_fold (
        .i_work (work),
        .o_grp  (grp)
    );

    // result register and serializer
    ucf_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work_vld  (work_vld),
        .i_grp       (grp),
        .o_work_take (work_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> design/ucf_chk.sv
// Port level checks for the case folder, bound to the top level
`timescale 1ns / 1ps

module ucf_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ucf_pkg::t_out o_out_data
);

    // reset empties the output side
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // line end only on the last byte of a transaction's group
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_line_end |-> o_out_data.out_last)
        else $error("line end without last");

    // with nothing waiting at the output the input side is never blocked
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

endmodule

bind utf8_case_fold_stream_top ucf_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
